FILE: rtl/mm64a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mm64a_pkg;

  localparam logic [63:0] MixMul   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MixShift = 47;

  // Multiply operation being run, one-hot.
  typedef enum logic [4:0] {
    OP_INIT  = 5'b00001,  // seed ^ (len * M)
    OP_KMIX  = 5'b00010,  // k = word * M, then xor-shift
    OP_KFIN  = 5'b00100,  // h ^= k * M
    OP_HASH  = 5'b01000,  // h = h * M (tail bytes folded in first for a tail beat)
    OP_FINAL = 5'b10000   // final mix multiply
  } op_e;

  typedef struct packed {
    logic load_item;
    logic mul_start;
    op_e  op;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic full;
    logic tail;
    logic mul_done;
    logic out_free;
  } sts_t;

  function automatic logic [63:0] xorshift(input logic [63:0] v);
    return v ^ (v >> MixShift);
  endfunction

  // Keeps the low n bytes of a word.
  function automatic logic [63:0] tail_mask(input logic [2:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[i*8 +: 8] = {8{3'(i) < n}};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/murmur64a_hash_stream_core.sv
`timescale 1ns / 1ps
`default_nettype none

// MurmurHash64A over a stream of little-endian 64-bit words. Load the seed
// through seed_we_i/seed_i while idle. Send one beat per word: first_i marks the
// opening beat (message_length_i is taken from it), byte_count_i gives the valid
// low bytes (8 or more is a full word, 1..7 a tail, 0 adds nothing) and last_i
// closes the message, after which one beat carrying hash_o comes out. Every
// 64-bit multiply by the mix constant runs on one shared 32 x 32 multiplier over
// three phases, with a start before them and a hand-back after. A beat takes
// 1 multiply for a first beat, 3 for a full word or 1 for a tail, and 1 more
// (plus the load of the output register) for a last beat. The block takes no
// new beat until it is through with the current one; the output register lets
// the next beat in while a finished hash waits.
module murmur64a_hash_stream_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        seed_we_i,
  input  wire logic [63:0] seed_i,
  // input beats
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] word_i,
  input  wire logic [3:0]  byte_count_i,
  input  wire logic        first_i,
  input  wire logic        last_i,
  input  wire logic [30:0] message_length_i,
  // result beats
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      hash_o
);
  import mm64a_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: accept, dispatch, walk the multiply steps, emit
  mm64a_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // running hash, seed, held beat, multiplier and output register
  mm64a_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .seed_we_i        (seed_we_i),
    .seed_i           (seed_i),
    .word_i           (word_i),
    .byte_count_i     (byte_count_i),
    .first_i          (first_i),
    .last_i           (last_i),
    .message_length_i (message_length_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .hash_o           (hash_o)
  );

endmodule

`default_nettype wire

FILE: rtl/mm64a_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// 64 x 64 -> low 64 multiply by the mix constant, one 32 x 32 product per cycle.
module mm64a_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  output logic             done_o,
  output logic [63:0]      p_o
);
  import mm64a_pkg::*;

  logic [1:0]  ph_q;
  logic        done_q;
  logic [63:0] a_q;
  logic [63:0] p0_q;
  logic [31:0] x_q;

  logic [31:0] op_x, op_y;
  logic [63:0] prod;

  // ph 1: lo*lo, ph 2: lo*hi, ph 3: hi*lo (cross terms low halves only)
  assign op_x = (ph_q == 2'd3) ? a_q[63:32] : a_q[31:0];
  assign op_y = (ph_q == 2'd2) ? MixMul[63:32] : MixMul[31:0];
  assign prod = 64'(op_x) * 64'(op_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= (ph_q == 2'd3);
      if (start_i) begin
        ph_q <= 2'd1;
      end else if (ph_q != 2'd0) begin
        ph_q <= (ph_q == 2'd3) ? 2'd0 : ph_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    unique case (ph_q)
      2'd1:    p0_q <= prod;
      2'd2:    x_q  <= prod[31:0];
      2'd3:    x_q  <= x_q + prod[31:0];
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign p_o    = p0_q + {x_q, 32'h0};

endmodule

`default_nettype wire

FILE: rtl/mm64a_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mm64a_dp (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            seed_we_i,
  input  wire logic [63:0]     seed_i,
  input  wire logic [63:0]     word_i,
  input  wire logic [3:0]      byte_count_i,
  input  wire logic            first_i,
  input  wire logic            last_i,
  input  wire logic [30:0]     message_length_i,
  input  wire logic            out_stall_i,
  input  wire mm64a_pkg::cmd_t cmd_i,
  output mm64a_pkg::sts_t      sts_o,
  output logic                 out_valid_o,
  output logic [63:0]          hash_o
);
  import mm64a_pkg::*;

  logic [63:0] seed_q, h_q, k_q, word_q, out_q;
  logic [30:0] len_q;
  logic [2:0]  cnt_q;
  logic        full_q, first_q, last_q, out_valid_q;

  logic        mul_done;
  logic [63:0] mul_p;
  logic [63:0] mul_a;

  always_comb begin
    unique case (cmd_i.op)
      OP_INIT:  mul_a = {33'd0, len_q};
      OP_KMIX:  mul_a = word_q;
      OP_KFIN:  mul_a = k_q;
      OP_HASH:  mul_a = full_q ? h_q : (h_q ^ (word_q & tail_mask(cnt_q)));
      OP_FINAL: mul_a = xorshift(h_q);
      default:  mul_a = h_q;
    endcase
  end

  mm64a_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      h_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (seed_we_i) begin
        seed_q <= seed_i;
      end
      if (cmd_i.commit) begin
        unique case (cmd_i.op)
          OP_INIT: h_q <= seed_q ^ mul_p;
          OP_KFIN: h_q <= h_q ^ mul_p;
          OP_HASH: h_q <= mul_p;
          default: ;
        endcase
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      word_q  <= word_i;
      cnt_q   <= byte_count_i[2:0];
      full_q  <= byte_count_i[3];
      first_q <= first_i;
      last_q  <= last_i;
      len_q   <= message_length_i;
    end
    if (cmd_i.commit && cmd_i.op == OP_KMIX) begin
      k_q <= xorshift(mul_p);
    end
    if (cmd_i.load_out) begin
      out_q <= xorshift(mul_p);
    end
  end

  always_comb begin
    sts_o.first    = first_q;
    sts_o.last     = last_q;
    sts_o.full     = full_q;
    sts_o.tail     = !full_q && (cnt_q != 3'd0);
    sts_o.mul_done = mul_done;
    sts_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign hash_o      = out_q;

endmodule

`default_nettype wire

FILE: rtl/mm64a_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mm64a_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire mm64a_pkg::sts_t sts_i,
  output logic                 in_stall_o,
  output mm64a_pkg::cmd_t      cmd_o
);
  import mm64a_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DISP  = 8'b00000010,
    S_INIT  = 8'b00000100,
    S_KMIX  = 8'b00001000,
    S_KFIN  = 8'b00010000,
    S_HASH  = 8'b00100000,
    S_FINAL = 8'b01000000,
    S_EMIT  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic   go_q;
  logic   in_mul;

  // Word step, else final mix, else idle, for the held item.
  function automatic state_e after_init(input sts_t s);
    priority if (s.full) return S_KMIX;
    else if (s.tail) return S_HASH;
    else if (s.last) return S_FINAL;
    else return S_IDLE;
  endfunction

  assign in_mul = (state_q == S_INIT) || (state_q == S_KMIX) || (state_q == S_KFIN) ||
                  (state_q == S_HASH) || (state_q == S_FINAL);

  always_comb begin
    state_d         = state_q;
    cmd_o.load_item = 1'b0;
    cmd_o.mul_start = go_q && in_mul;
    cmd_o.commit    = in_mul && sts_i.mul_done;
    cmd_o.load_out  = 1'b0;
    cmd_o.op        = OP_INIT;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DISP;
        end
      end
      S_DISP: state_d = sts_i.first ? S_INIT : after_init(sts_i);
      S_INIT: begin
        cmd_o.op = OP_INIT;
        if (sts_i.mul_done) state_d = after_init(sts_i);
      end
      S_KMIX: begin
        cmd_o.op = OP_KMIX;
        if (sts_i.mul_done) state_d = S_KFIN;
      end
      S_KFIN: begin
        cmd_o.op = OP_KFIN;
        if (sts_i.mul_done) state_d = S_HASH;
      end
      S_HASH: begin
        cmd_o.op = OP_HASH;
        if (sts_i.mul_done) state_d = sts_i.last ? S_FINAL : S_IDLE;
      end
      S_FINAL: begin
        cmd_o.op = OP_FINAL;
        if (sts_i.mul_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.op = OP_FINAL;
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      go_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= (state_d != state_q);  // kick the multiplier on entry
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/mm64a_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module mm64a_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] hash_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a held result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(hash_o))
    else $error("hash changed while stalled");

  // block is busy with a beat right after taking it
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken again straight after a beat");

  // a hash needs at least one multiply, never out the cycle after a beat
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result beat appeared too early");

endmodule

bind murmur64a_hash_stream_core mm64a_chk u_chk (.*);

`default_nettype wire
